>>> hw/rtl/phi_pkg.sv
// Package for the 2x2 phi coefficient block.
// Holds the request payload types and the fixed field widths; no dependencies.
package phi_pkg;

    // Fixed widths of the payload fields.
    localparam int CountFieldW = 12;
    localparam int PhiFieldW   = 17;

    // Input request: the four cell counts of one table.
    typedef struct packed {
        logic [CountFieldW-1:0] count_top_left;
        logic [CountFieldW-1:0] count_top_right;
        logic [CountFieldW-1:0] count_bottom_left;
        logic [CountFieldW-1:0] count_bottom_right;
    } t_in_req;

    // Output request: scaled phi and the empty margin flag.
    typedef struct packed {
        logic [PhiFieldW-1:0] phi_scaled;
        logic                 empty_margin;
    } t_out_req;

endpackage

>>> hw/rtl/phi_front.sv
// Front end of the phi pipeline: margins, cross products, P and D squared.
// Three register stages, each loaded by its own enable. Depends on phi_pkg.
module phi_front
    import phi_pkg::*;
#(
    parameter int CWE = 12
) (
    input  logic                i_clk,
    input  logic [2:0]          i_en,
    input  t_in_req             i_req,
    output logic [4*CWE+3:0]    o_p,
    output logic [4*CWE-1:0]    o_dsq,
    output logic                o_empty
);
    localparam int MW = CWE + 1;

    logic [CWE-1:0] a, b, c, d;
    logic [MW-1:0]  r_row1, r_row2, r_col1, r_col2;
    logic [2*CWE-1:0] r_ad, r_bc;
    logic [2*MW-1:0]  r_m1, r_m2;
    logic [2*CWE-1:0] r_diff;
    logic             r_empty_b;
    logic [4*CWE+3:0] r_p;
    logic [4*CWE-1:0] r_dsq;
    logic             r_empty_c;

    // Counts are cut to the configured count width.
    assign a = i_req.count_top_left[CWE-1:0];
    assign b = i_req.count_top_right[CWE-1:0];
    assign c = i_req.count_bottom_left[CWE-1:0];
    assign d = i_req.count_bottom_right[CWE-1:0];

    // Stage A: margin sums and the two cross products.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_row1 <= MW'(a) + MW'(b);
            r_row2 <= MW'(c) + MW'(d);
            r_col1 <= MW'(a) + MW'(c);
            r_col2 <= MW'(b) + MW'(d);
            r_ad   <= (2*CWE)'(a) * (2*CWE)'(d);
            r_bc   <= (2*CWE)'(b) * (2*CWE)'(c);
        end
    end

    // Stage B: margin pair products, absolute difference, empty check.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_m1      <= (2*MW)'(r_row1) * (2*MW)'(r_row2);
            r_m2      <= (2*MW)'(r_col1) * (2*MW)'(r_col2);
            r_diff    <= (r_ad >= r_bc) ? (r_ad - r_bc) : (r_bc - r_ad);
            r_empty_b <= (r_row1 == '0) || (r_row2 == '0) ||
                         (r_col1 == '0) || (r_col2 == '0);
        end
    end

    // Stage C: full margin product and squared difference.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_p       <= (4*MW)'(r_m1) * (4*MW)'(r_m2);
            r_dsq     <= (4*CWE)'(r_diff) * (4*CWE)'(r_diff);
            r_empty_c <= r_empty_b;
        end
    end

    assign o_p     = r_p;
    assign o_dsq   = r_dsq;
    assign o_empty = r_empty_c;

endmodule

>>> hw/rtl/phi_root.sv
// One bit stage of the restoring search for the largest q with q*q*P <= N.
// Keeps the residual N - q*q*P and q*P so each step is shift, add, compare.
module phi_root
    import phi_pkg::*;
#(
    parameter int W   = 72,
    parameter int PW  = 52,
    parameter int QW  = 17,
    parameter int BIT = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [W-1:0]  i_r,
    input  logic [W-1:0]  i_qp,
    input  logic [QW-1:0] i_q,
    input  logic [PW-1:0] i_p,
    input  logic          i_empty,
    output logic [W-1:0]  o_r,
    output logic [W-1:0]  o_qp,
    output logic [QW-1:0] o_q,
    output logic [PW-1:0] o_p,
    output logic          o_empty
);
    logic [W-1:0]  p_ext, t, n_r, n_qp;
    logic [QW-1:0] n_q;
    logic          take;
    logic [W-1:0]  r_r, r_qp;
    logic [QW-1:0] r_q;
    logic [PW-1:0] r_p;
    logic          r_empty;

    // Trial: (q + 2^k)^2 P - q^2 P = 2^(k+1) qP + 2^(2k) P.
    always_comb begin
        p_ext = W'(i_p);
        t     = (i_qp << (BIT + 1)) + (p_ext << (2 * BIT));
        take  = (i_r >= t);
        n_r   = take ? (i_r - t) : i_r;
        n_qp  = take ? (i_qp + (p_ext << BIT)) : i_qp;
        n_q   = i_q;
        n_q[BIT] = take;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r     <= n_r;
            r_qp    <= n_qp;
            r_q     <= n_q;
            r_p     <= i_p;
            r_empty <= i_empty;
        end
    end

    assign o_r     = r_r;
    assign o_qp    = r_qp;
    assign o_q     = r_q;
    assign o_p     = r_p;
    assign o_empty = r_empty;

endmodule

>>> hw/rtl/phi_coefficient_two_by_two.sv
// Top level of the 2x2 phi coefficient pipeline.
// Uses phi_pkg, phi_front and one phi_root per result bit.
//
//   Channel | Valid       | Ready       | Payload
//   input   | i_in_valid  | o_in_ready  | i_in_req  (t_in_req)
//   output  | o_out_valid | i_out_ready | o_out_req (t_out_req)
//
// One request per cycle enters while the output is not stalled; three front
// stages are followed by one stage per result bit of the square-root search.
// Reset clears only the stage valid bits; data registers are not reset.
// A stage loads when it is empty or the stage after it moves, so a stall
// at the output fills bubbles first and then holds every stage in place.
module phi_coefficient_two_by_two
    import phi_pkg::*;
#(
    parameter int COUNT_WIDTH   = 12,
    parameter int FRACTION_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_req
);
    localparam int CWE = (COUNT_WIDTH < CountFieldW) ? COUNT_WIDTH : CountFieldW;
    localparam int PW  = 4 * CWE + 4;
    localparam int W   = 4 * CWE + 2 * FRACTION_BITS + 7;
    localparam int QW  = FRACTION_BITS + 1;
    localparam int NS  = 3 + QW;

    logic [NS-1:0] r_vld, n_vld, en;

    // Stage enables ripple back from the output.
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_out_ready;
        for (int s = NS - 2; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
        for (int s = 0; s < NS; s++) begin
            if (en[s]) begin
                n_vld[s] = (s == 0) ? i_in_valid : r_vld[(s == 0) ? 0 : s - 1];
            end else begin
                n_vld[s] = r_vld[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready = en[0];

    logic [PW-1:0]    f_p;
    logic [4*CWE-1:0] f_dsq;
    logic             f_empty;

    phi_front #(.CWE(CWE)) u_front (
        .i_clk   (i_clk),
        .i_en    (en[2:0]),
        .i_req   (i_in_req),
        .o_p     (f_p),
        .o_dsq   (f_dsq),
        .o_empty (f_empty)
    );

    // Search chain; index 0 is the start value.
    logic [W-1:0]  c_r  [QW+1];
    logic [W-1:0]  c_qp [QW+1];
    logic [QW-1:0] c_q  [QW+1];
    logic [PW-1:0] c_p  [QW+1];
    logic          c_em [QW+1];

    assign c_r[0]  = W'(f_dsq) << (2 * FRACTION_BITS);
    assign c_qp[0] = '0;
    assign c_q[0]  = '0;
    assign c_p[0]  = f_p;
    assign c_em[0] = f_empty;

    for (genvar i = 0; i < QW; i++) begin : g_root
        phi_root #(
            .W   (W),
            .PW  (PW),
            .QW  (QW),
            .BIT (FRACTION_BITS - i)
        ) u_root (
            .i_clk   (i_clk),
            .i_en    (en[3+i]),
            .i_r     (c_r[i]),
            .i_qp    (c_qp[i]),
            .i_q     (c_q[i]),
            .i_p     (c_p[i]),
            .i_empty (c_em[i]),
            .o_r     (c_r[i+1]),
            .o_qp    (c_qp[i+1]),
            .o_q     (c_q[i+1]),
            .o_p     (c_p[i+1]),
            .o_empty (c_em[i+1])
        );
    end

    // Result cut or padded to the field width; forced to zero on empty margin.
    logic [PhiFieldW+QW-1:0] q_ext;
    assign q_ext       = {{PhiFieldW{1'b0}}, c_q[QW]};
    assign o_out_valid = r_vld[NS-1];
    assign o_out_req.phi_scaled   = c_em[QW] ? '0 : q_ext[PhiFieldW-1:0];
    assign o_out_req.empty_margin = c_em[QW];

    // An empty margin always reports zero.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.empty_margin |-> o_out_req.phi_scaled == '0)
        else $error("empty margin with nonzero phi");

    // A stalled result is never dropped by the pipeline.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("stalled result lost");

    // An empty pipeline tail never blocks the input.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !r_vld[0] |-> o_in_ready)
        else $error("input blocked with free stages");

endmodule

>>> sim/phi_checker.sv
// Checker for the 2x2 phi coefficient block: watches both channels,
// predicts each result with an exact integer square-root search and compares.
// Depends on phi_pkg for the request payload types.
module phi_checker
    import phi_pkg::*;
#(
    parameter int COUNT_WIDTH   = 12,
    parameter int FRACTION_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_ready,
    input  t_in_req  i_in_req,
    input  logic     i_out_valid,
    input  logic     i_out_ready,
    input  t_out_req i_out_req,
    output int       o_fail_count,
    output int       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_out_req phi_expected_q[$];

    // Largest q with q*q*P <= D*D*2^(2F), or the empty margin flag.
    function automatic t_out_req phi_of_table(t_in_req req);
        logic [15:0]  a, b, c, d;
        logic [63:0]  prod, diff;
        logic [191:0] rhs, lhs;
        logic [63:0]  q, cand;
        t_out_req     res;
        a = 16'(req.count_top_left & ((1 << COUNT_WIDTH) - 1));
        b = 16'(req.count_top_right & ((1 << COUNT_WIDTH) - 1));
        c = 16'(req.count_bottom_left & ((1 << COUNT_WIDTH) - 1));
        d = 16'(req.count_bottom_right & ((1 << COUNT_WIDTH) - 1));
        prod = 64'(a + b) * 64'(c + d) * 64'(a + c) * 64'(b + d);
        res = '0;
        if (prod == 0) begin
            res.empty_margin = 1'b1;
            return res;
        end
        diff = (64'(a) * d >= 64'(b) * c) ? 64'(a) * d - 64'(b) * c
                                          : 64'(b) * c - 64'(a) * d;
        rhs = 192'(diff * diff) << (2 * FRACTION_BITS);
        q = 0;
        for (int bit_idx = FRACTION_BITS; bit_idx >= 0; bit_idx--) begin
            cand = q | (64'd1 << bit_idx);
            lhs = 192'(cand) * 192'(cand) * 192'(prod);
            if (lhs <= rhs) q = cand;
        end
        res.phi_scaled = q[PhiFieldW-1:0];
        return res;
    endfunction

    assign o_pending = phi_expected_q.size();

    // Queue predictions on input requests, compare on output requests.
    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready) phi_expected_q.push_back(phi_of_table(i_in_req));
            if (i_out_valid && i_out_ready) begin
                if (phi_expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("Unexpected result: phi=%0d empty=%0b",
                                 i_out_req.phi_scaled, i_out_req.empty_margin);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = phi_expected_q.pop_front();
                    if (want.phi_scaled !== i_out_req.phi_scaled ||
                        want.empty_margin !== i_out_req.empty_margin) begin
                        if (o_fail_count < 10)
                            $display("Mismatch: expected phi=%0d empty=%0b, got phi=%0d empty=%0b",
                                     want.phi_scaled, want.empty_margin,
                                     i_out_req.phi_scaled, i_out_req.empty_margin);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> sim/tb_phi_coefficient_two_by_two.sv
// Testbench top for the 2x2 phi coefficient block: drives tables with random
// gaps and output stalls and gives the verdict. Depends on phi_pkg and phi_checker.
module tb_phi_coefficient_two_by_two
    import phi_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Latency    = 20;
    localparam int WatchLimit = 2000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    t_in_req  in_req = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_out_req out_req;
    int       fail_count;
    int       pending;
    int       sender_idle_pct = 31;
    int       receiver_idle_pct = 63;
    logic     hold_off = 1'b0;
    int       quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    phi_coefficient_two_by_two uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_req(in_req),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_req(out_req)
    );

    phi_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_req(in_req),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_req(out_req),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: random stalls, or a long hold-off when asked.
    always @(posedge i_clk) begin
        out_ready <= !hold_off && ($urandom_range(99) >= receiver_idle_pct);
    end

    // Watchdog on cycles with no accepted request.
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offer one table and wait until it is accepted.
    task automatic send_table(input logic [11:0] a, b, c, d);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req <= '{a, b, c, d};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // Random table: mostly full range, sometimes small counts or zero cells.
    task automatic send_random_table();
        logic [11:0] cnt[4];
        int          pick;
        pick = $urandom_range(9);
        for (int k = 0; k < 4; k++) begin
            if (pick < 5) cnt[k] = 12'($urandom);
            else if (pick < 8) cnt[k] = 12'($urandom_range(15));
            else cnt[k] = ($urandom_range(2) == 0) ? 12'd0 : 12'($urandom);
        end
        send_table(cnt[0], cnt[1], cnt[2], cnt[3]);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, empty margins, zero difference, perfect association.
        send_table(0, 0, 0, 0);
        send_table(4095, 4095, 4095, 4095);
        send_table(4095, 0, 0, 4095);
        send_table(0, 4095, 4095, 0);
        send_table(4095, 4095, 0, 0);
        send_table(0, 0, 4095, 4095);
        send_table(4095, 0, 4095, 0);
        send_table(0, 4095, 0, 4095);
        send_table(1, 0, 0, 0);
        send_table(0, 0, 0, 1);
        send_table(1, 0, 0, 1);
        send_table(2, 4, 3, 6);
        send_table(4095, 1, 1, 4095);
        send_table(1, 4095, 4095, 1);
        send_table(4094, 2730, 1365, 2047);
        send_table(1, 2, 3, 4);

        // Long receiver hold-off while tables keep coming, so the pipe fills.
        hold_off <= 1'b1;
        fork
            begin
                repeat (60) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            repeat (40) send_random_table();
        join

        for (int ph = 0; ph < 3; ph++) begin
            sender_idle_pct   = (ph == 0) ? 31 : (ph == 1) ? 63 : 0;
            receiver_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 31 : 0;
            repeat (135) send_random_table();
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (Latency + 5) @(posedge i_clk);
        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
